FILE: sv/apwd_pkg.sv
// Shared types and constants for the audio presence window detector.
package apwd_pkg;

  // Fixed field widths.
  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned LEN_CFG_W  = 9;
  localparam int unsigned BITS_CFG_W = 6;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned CFG_IDX_W  = 1;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_BITS   = 1'b1;

  // Configuration reset values.
  localparam logic [LEN_CFG_W-1:0]  PERIOD_LENGTH_RESET = 9'd48;
  localparam logic [BITS_CFG_W-1:0] SAMPLE_BITS_RESET   = 6'd16;

  // Legal span of the sample width.
  localparam logic [BITS_CFG_W-1:0] BITS_MIN = 6'd8;
  localparam logic [BITS_CFG_W-1:0] BITS_MAX = 6'd32;

  // Verdict score: 100*sound - 51*periods, kept as a running signed value.
  localparam int unsigned SCORE_W = 41;
  localparam logic signed [SCORE_W-1:0] SOUND_WEIGHT  = 41'sd100;
  localparam logic signed [SCORE_W-1:0] PERIOD_WEIGHT = 41'sd51;
  localparam logic signed [SCORE_W-1:0] SCORE_RESET   = 41'sd100;

  typedef logic [BITS_CFG_W-1:0] bits_t;
  typedef logic [SAMPLE_W-1:0]   sample_t;

  // One folded sample on its way to the window tracker.
  typedef struct packed {
    sample_t sample;
    logic    first;
    logic    last;
    bits_t   eff_bits;
  } fold_word_t;

  // Extremes of one finished period.
  typedef struct packed {
    sample_t wmin;
    sample_t wmax;
    bits_t   eff_bits;
  } span_t;

  // Clamp the configured sample width into its legal span.
  function automatic bits_t clamp_bits(bits_t b);
    bits_t r;
    if (b < BITS_MIN) begin
      r = BITS_MIN;
    end else if (b > BITS_MAX) begin
      r = BITS_MAX;
    end else begin
      r = b;
    end
    return r;
  endfunction

endpackage

FILE: sv/apwd_fold.sv
// Input stage: folds each sample, tracks its position in the period, registers it.
module apwd_fold #(
  parameter int unsigned PERIOD_MAX = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic [apwd_pkg::SAMPLE_W-1:0]       raw_sample,
  input  logic [apwd_pkg::LEN_CFG_W-1:0]      period_length,
  input  apwd_pkg::bits_t                     eff_bits,
  input  logic                                take,
  output logic                                word_valid,
  output apwd_pkg::fold_word_t                word
);

  localparam int unsigned PW = $clog2(PERIOD_MAX);
  localparam int unsigned LW = $clog2(PERIOD_MAX + 1);
  localparam int unsigned CW = (LW > apwd_pkg::LEN_CFG_W) ? LW : apwd_pkg::LEN_CFG_W;

  logic [PW-1:0]        pos;
  logic [PW-1:0]        pos_next;
  logic [CW-1:0]        len_wide;
  logic [LW-1:0]        eff_len;
  logic [LW-1:0]        len_m1;
  logic                 last;
  logic                 free;
  logic                 accept;
  apwd_pkg::sample_t    mask;
  apwd_pkg::sample_t    masked;
  logic [4:0]           sign_idx;
  apwd_pkg::fold_word_t word_next;

  // Handshake: the stage frees up when empty or when its word moves on.
  assign free         = !word_valid || take;
  assign accept       = sample_valid && free;
  assign sample_stall = !free;

  // Effective period length: zero counts as one, long values saturate.
  always_comb begin
    len_wide = CW'(period_length);
    if (period_length == '0) begin
      eff_len = LW'(1);
    end else if (len_wide > CW'(PERIOD_MAX)) begin
      eff_len = LW'(PERIOD_MAX);
    end else begin
      eff_len = LW'(len_wide);
    end
    len_m1 = eff_len - LW'(1);
  end

  // The period ends at the first sample at or past the last position.
  assign last     = LW'(pos) >= len_m1;
  assign pos_next = last ? '0 : pos + PW'(1);

  // Keep the low sample bits and fold negative values onto positives.
  always_comb begin
    for (int i = 0; i < apwd_pkg::SAMPLE_W; i++) begin
      mask[i] = (apwd_pkg::BITS_CFG_W'(i) < eff_bits);
    end
    masked   = raw_sample & mask;
    sign_idx = 5'(eff_bits - apwd_pkg::BITS_CFG_W'(1));
    word_next.sample   = masked[sign_idx] ? (~raw_sample & mask) : masked;
    word_next.first    = (pos == '0);
    word_next.last     = last;
    word_next.eff_bits = eff_bits;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
      pos        <= '0;
    end else begin
      if (free) begin
        word_valid <= sample_valid;
      end
      if (accept) begin
        pos <= pos_next;
      end
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      word <= word_next;
    end
  end

endmodule

FILE: sv/apwd_window.sv
// Window tracker: keeps the running minimum and maximum and hands off each finished period.
module apwd_window (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 word_valid,
  input  apwd_pkg::fold_word_t word,
  output logic                 take,
  input  logic                 span_take,
  output logic                 span_valid,
  output apwd_pkg::span_t      span
);

  apwd_pkg::sample_t wmin;
  apwd_pkg::sample_t wmax;
  apwd_pkg::sample_t wmin_next;
  apwd_pkg::sample_t wmax_next;
  logic              span_free;

  // A word that does not end a period is always taken; a closing word
  // needs room in the span register.
  assign span_free = !span_valid || span_take;
  assign take      = word_valid && (!word.last || span_free);

  // The first sample of a period restarts both extremes.
  always_comb begin
    if (word.first) begin
      wmin_next = word.sample;
      wmax_next = word.sample;
    end else begin
      wmin_next = (word.sample < wmin) ? word.sample : wmin;
      wmax_next = (word.sample > wmax) ? word.sample : wmax;
    end
  end

  // Control state and running extremes.
  always_ff @(posedge clk) begin
    if (rst) begin
      span_valid <= 1'b0;
      wmin       <= '0;
      wmax       <= '0;
    end else begin
      if (span_free) begin
        span_valid <= take && word.last;
      end
      if (take) begin
        wmin <= wmin_next;
        wmax <= wmax_next;
      end
    end
  end

  // Period hand-off payload.
  always_ff @(posedge clk) begin
    if (take && word.last && span_free) begin
      span.wmin     <= wmin_next;
      span.wmax     <= wmax_next;
      span.eff_bits <= word.eff_bits;
    end
  end

endmodule

FILE: sv/apwd_tally.sv
// Result stages: range and sound flag, then the counters, verdict and output register.
module apwd_tally (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          span_valid,
  input  apwd_pkg::span_t               span,
  output logic                          span_take,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [apwd_pkg::SAMPLE_W-1:0] period_range,
  output logic                          sound_flag,
  output logic [apwd_pkg::CNT_W-1:0]    sound_periods,
  output logic [apwd_pkg::CNT_W-1:0]    total_periods,
  output logic                          verdict_ok
);

  logic                                 mid_valid;
  apwd_pkg::sample_t                    mid_range;
  logic                                 mid_flag;
  logic                                 mid_free;
  logic                                 mid_take;
  logic                                 out_free;
  apwd_pkg::sample_t                    range_c;
  apwd_pkg::sample_t                    thr_c;
  logic [apwd_pkg::CNT_W-1:0]           sound_cnt;
  logic [apwd_pkg::CNT_W-1:0]           period_cnt;
  logic [apwd_pkg::CNT_W-1:0]           sound_cnt_next;
  logic [apwd_pkg::CNT_W-1:0]           period_cnt_next;
  logic signed [apwd_pkg::SCORE_W-1:0]  score;
  logic signed [apwd_pkg::SCORE_W-1:0]  score_next;
  logic                                 sound_inc;
  logic                                 period_inc;

  // Stall chain between the two stages and the receiver.
  assign out_free  = !result_valid || !result_stall;
  assign mid_take  = mid_valid && out_free;
  assign mid_free  = !mid_valid || mid_take;
  assign span_take = span_valid && mid_free;

  // Range of the period against a quarter of full scale.
  assign range_c = span.wmax - span.wmin;
  assign thr_c   = apwd_pkg::SAMPLE_W'(1) << (span.eff_bits - apwd_pkg::BITS_CFG_W'(2));

  // Saturating counters; the score tracks 100*sound - 51*periods exactly.
  always_comb begin
    sound_inc       = mid_flag && !(&sound_cnt);
    period_inc      = !(&period_cnt);
    sound_cnt_next  = sound_cnt + apwd_pkg::CNT_W'(sound_inc);
    period_cnt_next = period_cnt + apwd_pkg::CNT_W'(period_inc);
    score_next      = score
                    + (sound_inc ? apwd_pkg::SOUND_WEIGHT : '0)
                    - (period_inc ? apwd_pkg::PERIOD_WEIGHT : '0);
  end

  // Control state and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid    <= 1'b0;
      result_valid <= 1'b0;
      sound_cnt    <= apwd_pkg::CNT_W'(1);
      period_cnt   <= '0;
      score        <= apwd_pkg::SCORE_RESET;
    end else begin
      if (mid_free) begin
        mid_valid <= span_valid;
      end
      if (out_free) begin
        result_valid <= mid_valid;
      end
      if (mid_take) begin
        sound_cnt  <= sound_cnt_next;
        period_cnt <= period_cnt_next;
        score      <= score_next;
      end
    end
  end

  // Payload registers of both stages.
  always_ff @(posedge clk) begin
    if (span_take) begin
      mid_range <= range_c;
      mid_flag  <= (range_c > thr_c);
    end
    if (mid_take) begin
      period_range  <= mid_range;
      sound_flag    <= mid_flag;
      sound_periods <= sound_cnt_next;
      total_periods <= period_cnt_next;
      verdict_ok    <= !score_next[apwd_pkg::SCORE_W-1];
    end
  end

endmodule

FILE: sv/audio_presence_window_detector.sv
// Top level of the audio presence window detector.
//
// Usage: raw samples enter on the sample channel (sample_valid, sample_stall,
// raw_sample), one word per cycle unless stalled. The block folds each sample,
// tracks the minimum and maximum over a period of period_length samples, and
// at the end of each period sends one word on the result channel
// (result_valid, result_stall): the range, a sound flag, the running sound
// and period counts and the verdict. Samples that do not close a period
// produce no word.
// A closing sample passes through the input, span, middle and result registers.
// Throughput: one sample per cycle while sample_stall is low.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 period
// length, 1 sample width); write only while the block is idle.
// Reset: clears the pipeline, restores period length 48 and sample width 16,
// sound count to one and period count to zero.
// Stall: a stalled result holds; the stages behind it keep filling. Samples
// that do not close a period still pass, and sample_stall rises only when the
// span, middle and result stages are full and the input stage holds a closing
// sample.
module audio_presence_window_detector #(
  parameter int unsigned PERIOD_MAX = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  logic [apwd_pkg::SAMPLE_W-1:0]     raw_sample,
  input  logic                              cfg_we,
  input  logic [apwd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [apwd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [apwd_pkg::SAMPLE_W-1:0]     period_range,
  output logic                              sound_flag,
  output logic [apwd_pkg::CNT_W-1:0]        sound_periods,
  output logic [apwd_pkg::CNT_W-1:0]        total_periods,
  output logic                              verdict_ok
);

  logic [apwd_pkg::LEN_CFG_W-1:0] period_length;
  apwd_pkg::bits_t                sample_bits;
  apwd_pkg::bits_t                eff_bits;
  logic                           word_valid;
  apwd_pkg::fold_word_t           word;
  logic                           word_take;
  logic                           span_valid;
  apwd_pkg::span_t                span;
  logic                           span_take;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      period_length <= apwd_pkg::PERIOD_LENGTH_RESET;
      sample_bits   <= apwd_pkg::SAMPLE_BITS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        apwd_pkg::REG_PERIOD_LENGTH: period_length <= cfg_data[apwd_pkg::LEN_CFG_W-1:0];
        apwd_pkg::REG_SAMPLE_BITS:   sample_bits   <= cfg_data[apwd_pkg::BITS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff_bits = apwd_pkg::clamp_bits(sample_bits);

  // Input fold and position tracking.
  apwd_fold #(
    .PERIOD_MAX(PERIOD_MAX)
  ) u_fold (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .raw_sample   (raw_sample),
    .period_length(period_length),
    .eff_bits     (eff_bits),
    .take         (word_take),
    .word_valid   (word_valid),
    .word         (word)
  );

  // Running minimum and maximum.
  apwd_window u_window (
    .clk       (clk),
    .rst       (rst),
    .word_valid(word_valid),
    .word      (word),
    .take      (word_take),
    .span_take (span_take),
    .span_valid(span_valid),
    .span      (span)
  );

  // Range, flag, counters and result register.
  apwd_tally u_tally (
    .clk          (clk),
    .rst          (rst),
    .span_valid   (span_valid),
    .span         (span),
    .span_take    (span_take),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .period_range (period_range),
    .sound_flag   (sound_flag),
    .sound_periods(sound_periods),
    .total_periods(total_periods),
    .verdict_ok   (verdict_ok)
  );

endmodule

FILE: sim/audio_presence_window_detector_tb.sv
// Self-checking testbench for the audio presence window detector.
module audio_presence_window_detector_tb;

  localparam int unsigned WIN_MAX = 256;

  // One period summary as it leaves the block.
  typedef struct packed {
    logic [apwd_pkg::SAMPLE_W-1:0] span;
    logic                          loud;
    logic [apwd_pkg::CNT_W-1:0]    sound_cnt;
    logic [apwd_pkg::CNT_W-1:0]    total_cnt;
    logic                          ok;
  } period_result_t;

  // Per-word note: an optional hand-written expectation for the closing word.
  typedef struct {
    bit             has_want;
    period_result_t want;
  } word_note_t;

  typedef enum logic {ROW_REG, ROW_WORD} row_kind_t;

  typedef struct {
    row_kind_t                          kind;
    logic [apwd_pkg::CFG_IDX_W-1:0]     idx;
    logic [apwd_pkg::CFG_DATA_W-1:0]    val;
    apwd_pkg::sample_t                  word;
    bit                                 has_want;
    period_result_t                     want;
  } dir_row_t;

  logic                             clk;
  logic                             rst = 1'b1;
  logic                             sample_valid = 1'b0;
  logic                             sample_stall;
  apwd_pkg::sample_t                raw_sample = '0;
  logic                             cfg_we = 1'b0;
  logic [apwd_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [apwd_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                             result_valid;
  logic                             result_stall = 1'b0;
  logic [apwd_pkg::SAMPLE_W-1:0]    period_range;
  logic                             sound_flag;
  logic [apwd_pkg::CNT_W-1:0]       sound_periods;
  logic [apwd_pkg::CNT_W-1:0]       total_periods;
  logic                             verdict_ok;

  audio_presence_window_detector #(.PERIOD_MAX(WIN_MAX)) DUT (
    .clk           (clk),
    .rst           (rst),
    .sample_valid  (sample_valid),
    .sample_stall  (sample_stall),
    .raw_sample    (raw_sample),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .period_range  (period_range),
    .sound_flag    (sound_flag),
    .sound_periods (sound_periods),
    .total_periods (total_periods),
    .verdict_ok    (verdict_ok)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  // Predictor state: configuration, window extremes and running counts.
  logic [apwd_pkg::LEN_CFG_W-1:0]  len_reg = apwd_pkg::PERIOD_LENGTH_RESET;
  logic [apwd_pkg::BITS_CFG_W-1:0] width_reg = apwd_pkg::SAMPLE_BITS_RESET;
  logic [apwd_pkg::SAMPLE_W-1:0]   win_lo = '0;
  logic [apwd_pkg::SAMPLE_W-1:0]   win_hi = '0;
  int unsigned                     win_pos = 0;
  logic [apwd_pkg::CNT_W-1:0]      sound_cnt = apwd_pkg::CNT_W'(1);
  logic [apwd_pkg::CNT_W-1:0]      period_cnt = '0;

  period_result_t        period_q[$];
  word_note_t            note_q[$];
  int unsigned           mismatches = 0;
  int unsigned           burst_left = 0;
  int unsigned           words_sent = 0;
  logic [11:0]           stall_tick = '0;
  dir_row_t              dir_tab[$];

  // Sample width in use for a register value.
  function automatic int unsigned eff_width(logic [apwd_pkg::BITS_CFG_W-1:0] b);
    return (b < 8) ? 8 : ((b > 32) ? 32 : b);
  endfunction

  // Period length in use for a register value.
  function automatic int unsigned eff_len(logic [apwd_pkg::LEN_CFG_W-1:0] l);
    return (l == 0) ? 1 : ((l > WIN_MAX) ? WIN_MAX : l);
  endfunction

  // Folds one sample into the window; returns 1 when it closes the period.
  function automatic bit fold_into_window(input apwd_pkg::sample_t raw,
                                          output period_result_t r);
    int unsigned nb;
    int unsigned len;
    logic [63:0] mask;
    logic [63:0] s;
    logic [apwd_pkg::SAMPLE_W-1:0] f;
    nb = eff_width(width_reg);
    len = eff_len(len_reg);
    mask = (64'd1 << nb) - 64'd1;
    s = {32'd0, raw} & mask;
    if (s[nb-1]) begin
      s = ~s & mask;
    end
    f = s[apwd_pkg::SAMPLE_W-1:0];
    r = '0;
    if (win_pos == 0) begin
      win_lo = f;
      win_hi = f;
    end else begin
      if (f > win_hi) win_hi = f;
      if (f < win_lo) win_lo = f;
    end
    if (win_pos + 1 < len) begin
      win_pos++;
      return 1'b0;
    end
    win_pos = 0;
    r.span = win_hi - win_lo;
    r.loud = ({32'd0, r.span} > (64'd1 << (nb - 2)));
    if (period_cnt != '1) period_cnt++;
    if (r.loud && sound_cnt != '1) sound_cnt++;
    r.sound_cnt = sound_cnt;
    r.total_cnt = period_cnt;
    r.ok = ({32'd0, sound_cnt} * 64'd100 >= {32'd0, period_cnt} * 64'd51);
    return 1'b1;
  endfunction

  // Picks a word: mostly random, some quiet, a few at the folding extremes.
  function automatic apwd_pkg::sample_t pick_word(int unsigned nb, int unsigned quiet_pct);
    int unsigned k;
    apwd_pkg::sample_t v;
    k = $urandom_range(0, 99);
    if (k < 5) begin
      case ($urandom_range(0, 3))
        0: v = '0;
        1: v = '1;
        2: v = apwd_pkg::sample_t'(64'd1 << (nb - 1));
        default: v = apwd_pkg::sample_t'((64'd1 << (nb - 1)) - 64'd1);
      endcase
    end else if (k < quiet_pct) begin
      v = $urandom_range(0, 1 << (nb - 3));
      if ($urandom_range(0, 1)) v = ~v;
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  // Checker: predicts on every accepted sample and compares every accepted result.
  always @(posedge clk) begin
    word_note_t     note;
    period_result_t pred;
    period_result_t got;
    period_result_t want;
    if (!rst) begin
      if (cfg_we) begin
        if (cfg_index == apwd_pkg::REG_PERIOD_LENGTH) begin
          len_reg <= cfg_data[apwd_pkg::LEN_CFG_W-1:0];
        end else if (cfg_index == apwd_pkg::REG_SAMPLE_BITS) begin
          width_reg <= cfg_data[apwd_pkg::BITS_CFG_W-1:0];
        end
      end
      if (sample_valid && !sample_stall) begin
        note = note_q.pop_front();
        if (fold_into_window(raw_sample, pred)) begin
          period_q.push_back(note.has_want ? note.want : pred);
        end
      end
      if (result_valid && !result_stall) begin
        got = '{period_range, sound_flag, sound_periods, total_periods, verdict_ok};
        if (period_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected result: span=%h loud=%b sound=%0d total=%0d ok=%b",
                     got.span, got.loud, got.sound_cnt, got.total_cnt, got.ok);
          end
          mismatches++;
        end else begin
          want = period_q.pop_front();
          if (got.span !== want.span || got.loud !== want.loud ||
              got.sound_cnt !== want.sound_cnt || got.total_cnt !== want.total_cnt ||
              got.ok !== want.ok) begin
            if (mismatches < 10) begin
              $display("mismatch: expected span=%h loud=%b sound=%0d total=%0d ok=%b",
                       want.span, want.loud, want.sound_cnt, want.total_cnt, want.ok);
              $display("          actual   span=%h loud=%b sound=%0d total=%0d ok=%b",
                       got.span, got.loud, got.sound_cnt, got.total_cnt, got.ok);
            end
            mismatches++;
          end
        end
      end
    end
  end

  // Receiver stall pattern: free, random, periodic and long blocks in turn.
  always @(negedge clk) begin
    stall_tick <= stall_tick + 1'b1;
    case (stall_tick[9:8])
      2'd0: result_stall <= 1'b0;
      2'd1: result_stall <= ($urandom_range(0, 1) == 0);
      2'd2: result_stall <= (stall_tick[2:0] < 3'd3);
      default: result_stall <= stall_tick[4];
    endcase
  end

  // Sends one word in bursts with random gaps between them.
  task automatic send_word(input apwd_pkg::sample_t w, input bit has_want,
                           input period_result_t want);
    int unsigned gap;
    word_note_t  note;
    note.has_want = has_want;
    note.want = want;
    note_q.push_back(note);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        @(negedge clk);
        sample_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    sample_valid <= 1'b1;
    raw_sample <= w;
    do @(posedge clk); while (sample_stall);
    burst_left--;
    words_sent++;
  endtask

  // Stops sending and waits until every expected word has arrived.
  task automatic wait_idle();
    @(negedge clk);
    sample_valid <= 1'b0;
    burst_left = 0;
    while (period_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [apwd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [apwd_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Table builders for the directed part.
  function automatic void add_reg(logic [apwd_pkg::CFG_IDX_W-1:0] idx,
                                  logic [apwd_pkg::CFG_DATA_W-1:0] val);
    dir_row_t row;
    row = '{ROW_REG, idx, val, '0, 1'b0, '0};
    dir_tab.push_back(row);
  endfunction

  function automatic void add_word(apwd_pkg::sample_t w);
    dir_row_t row;
    row = '{ROW_WORD, '0, '0, w, 1'b0, '0};
    dir_tab.push_back(row);
  endfunction

  function automatic void add_checked(apwd_pkg::sample_t w,
                                      logic [apwd_pkg::SAMPLE_W-1:0] span, logic loud,
                                      logic [apwd_pkg::CNT_W-1:0] snd,
                                      logic [apwd_pkg::CNT_W-1:0] tot, logic ok);
    dir_row_t row;
    row = '{ROW_WORD, '0, '0, w, 1'b1, '{span, loud, snd, tot, ok}};
    dir_tab.push_back(row);
  endfunction

  // Stimulus: directed table, random phases, then the longest period.
  initial begin
    int unsigned len_v;
    logic [apwd_pkg::BITS_CFG_W-1:0] width_v;
    int unsigned quiet_pct;
    int unsigned n;

    // Two-word periods at 16 bits: full swing, folded negatives, threshold edge,
    // and ignored upper bits.
    add_reg(apwd_pkg::REG_PERIOD_LENGTH, 9'd2);
    add_reg(apwd_pkg::REG_SAMPLE_BITS, 9'd16);
    add_word(32'h0000_0000);
    add_checked(32'h0000_7FFF, 32'h7FFF, 1'b1, 2, 1, 1'b1);
    add_word(32'h0000_FFFF);
    add_checked(32'h0000_8000, 32'h7FFF, 1'b1, 3, 2, 1'b1);
    add_word(32'h0000_4000);
    add_checked(32'h0000_0000, 32'h4000, 1'b0, 3, 3, 1'b1);
    add_word(32'h0000_0000);
    add_checked(32'h0000_4001, 32'h4001, 1'b1, 4, 4, 1'b1);
    add_word(32'hFFFF_0005);
    add_checked(32'h1234_0005, 32'h0000, 1'b0, 4, 5, 1'b1);
    // Narrowest and widest samples.
    add_reg(apwd_pkg::REG_SAMPLE_BITS, 9'd8);
    add_word(32'h0000_0080);
    add_word(32'h0000_007F);
    add_word(32'h0000_0000);
    add_word(32'h0000_007F);
    add_reg(apwd_pkg::REG_SAMPLE_BITS, 9'd32);
    add_word(32'h0000_0000);
    add_word(32'h7FFF_FFFF);
    add_word(32'hFFFF_FFFF);
    add_word(32'h4000_0000);
    // Zero length and zero width fall back to their minimums.
    add_reg(apwd_pkg::REG_PERIOD_LENGTH, 9'd0);
    add_reg(apwd_pkg::REG_SAMPLE_BITS, 9'd0);
    add_word(32'h0000_00A5);
    add_word(32'h0000_005A);
    // Width above range; then the length shrinks in the middle of a period.
    add_reg(apwd_pkg::REG_PERIOD_LENGTH, 9'd3);
    add_reg(apwd_pkg::REG_SAMPLE_BITS, 9'd63);
    add_word(32'h8000_0000);
    add_reg(apwd_pkg::REG_PERIOD_LENGTH, 9'd1);
    add_word(32'h1234_5678);
    // Width changes in the middle of a period.
    add_reg(apwd_pkg::REG_PERIOD_LENGTH, 9'd3);
    add_word(32'h0000_0001);
    add_reg(apwd_pkg::REG_SAMPLE_BITS, 9'd12);
    add_word(32'h0000_0FFF);
    add_word(32'h0000_0800);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_REG) begin
        wait_idle();
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        send_word(dir_tab[i].word, dir_tab[i].has_want, dir_tab[i].want);
      end
    end

    // Random phases: mostly short periods, with widths across and beyond the range.
    while (words_sent < 280) begin
      case ($urandom_range(0, 9))
        0: len_v = 0;
        1: len_v = $urandom_range(17, 64);
        default: len_v = $urandom_range(1, 16);
      endcase
      case ($urandom_range(0, 7))
        0: width_v = apwd_pkg::BITS_CFG_W'($urandom_range(0, 63));
        1: width_v = apwd_pkg::BITS_MIN;
        2: width_v = apwd_pkg::BITS_MAX;
        default: width_v = apwd_pkg::BITS_CFG_W'($urandom_range(8, 32));
      endcase
      quiet_pct = $urandom_range(0, 100);
      n = $urandom_range(4, 48);
      wait_idle();
      write_reg(apwd_pkg::REG_PERIOD_LENGTH, apwd_pkg::CFG_DATA_W'(len_v));
      write_reg(apwd_pkg::REG_SAMPLE_BITS, {3'($urandom_range(0, 7)), width_v});
      repeat (n) send_word(pick_word(eff_width(width_v), quiet_pct), 1'b0, '0);
    end

    // Longest period, reached through a length above it that saturates.
    width_v = apwd_pkg::BITS_CFG_W'($urandom_range(8, 32));
    quiet_pct = $urandom_range(0, 100);
    wait_idle();
    write_reg(apwd_pkg::REG_PERIOD_LENGTH, 9'd511);
    write_reg(apwd_pkg::REG_SAMPLE_BITS, apwd_pkg::CFG_DATA_W'(width_v));
    repeat (WIN_MAX + 4) send_word(pick_word(eff_width(width_v), quiet_pct), 1'b0, '0);

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && period_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
